/* rtl/deadlock_detection_engine_defines.svh */
// Assertion macros for the deadlock detection engine checker.
// Used by the checker module only.
`ifndef DEADLOCK_DETECTION_ENGINE_DEFINES_SVH
`define DEADLOCK_DETECTION_ENGINE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define DDE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dde check failed");

// next-cycle implication checked outside reset
`define DDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dde check failed");

`endif

/* rtl/dde_pkg.sv */
// Package for the deadlock detection engine: payload structs and kind codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dde_pkg;
    localparam logic [1:0] K_SET_AVAIL = 2'd0;
    localparam logic [1:0] K_ADD_HELD  = 2'd1;
    localparam logic [1:0] K_ADD_WAIT  = 2'd2;
    localparam logic [1:0] K_RUN       = 2'd3;

    localparam int AVAIL_W = 12;
    localparam int COUNT_W = 8;
    localparam logic [AVAIL_W-1:0] AVAIL_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] process_slot;
        logic [2:0] resource_index;
        logic [7:0] amount;
    } t_in_item;

    typedef struct packed {
        logic [3:0] deadlocked_slot;
        logic       is_summary;
        logic       deadlock_found;
        logic       last;
    } t_out_item;

    // per-cell control from the sequencer
    typedef struct packed {
        logic clear;
        logic shift;
        logic load;
        logic fin;
    } t_cell_ctl;
endpackage
`default_nettype wire

/* rtl/dde_cell.sv */
// One resource column cell: available count, working count, and one
// shift ring of held/waited counts for every slot. Depends on dde_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dde_cell #(
    parameter int NP = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dde_pkg::t_cell_ctl i_ctl,
    input  wire logic              i_set_avail,
    input  wire logic [7:0]        i_amount,
    input  wire logic              i_add_held,
    input  wire logic              i_add_wait,
    input  wire logic [$clog2(NP)-1:0] i_slot,
    input  wire logic              i_active,
    input  wire logic              i_fits_in,
    output logic                   o_fits
);
    logic [dde_pkg::AVAIL_W-1:0] r_avail, r_work, n_work;
    logic [dde_pkg::COUNT_W-1:0] r_held [NP];
    logic [dde_pkg::COUNT_W-1:0] r_wait [NP];
    logic [dde_pkg::AVAIL_W:0]   w_sum;

    // slot 0 of the ring is the one under examination
    assign o_fits = i_fits_in && (!i_active || (r_work >= {4'd0, r_wait[0]}));
    assign w_sum  = {1'b0, r_work} + {5'd0, r_held[0]};

    always_comb begin
        n_work = r_work;
        if (i_ctl.load) begin
            n_work = r_avail;
        end else if (i_ctl.fin && i_active) begin
            n_work = w_sum[dde_pkg::AVAIL_W] ? dde_pkg::AVAIL_MAX
                                             : w_sum[dde_pkg::AVAIL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail <= '0;
            r_work  <= '0;
            for (int i = 0; i < NP; i++) begin
                r_held[i] <= '0;
                r_wait[i] <= '0;
            end
        end else begin
            r_work <= n_work;
            if (i_set_avail) begin
                r_avail <= {4'd0, i_amount};
            end
            if (i_ctl.clear) begin
                for (int i = 0; i < NP; i++) begin
                    r_held[i] <= '0;
                    r_wait[i] <= '0;
                end
            end else if (i_ctl.shift) begin
                for (int i = 0; i < NP; i++) begin
                    r_held[i] <= r_held[(i + 1) % NP];
                    r_wait[i] <= r_wait[(i + 1) % NP];
                end
            end else begin
                if (i_add_held && r_held[i_slot] != dde_pkg::COUNT_MAX) begin
                    r_held[i_slot] <= r_held[i_slot] + 1'b1;
                end
                if (i_add_wait && r_wait[i_slot] != dde_pkg::COUNT_MAX) begin
                    r_wait[i_slot] <= r_wait[i_slot] + 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/deadlock_detection_engine.sv */
// Top level of the deadlock detection engine: sequencer plus a chain of
// resource cells. Depends on dde_pkg and dde_cell.
//
//  channel | dir | handshake       | payload
//  in      | in  | valid / stall   | dde_pkg::t_in_item
//  out     | out | valid / stall   | dde_pkg::t_out_item
//  cfg     | in  | valid / ready   | resource_count, 4 bits
//
// During a run the slot rings rotate one slot a cycle through every cell,
// and a full turn with no slot finished ends the search; each slot still
// unfinished is then reported, followed by the summary.
// Reset is synchronous and clears all tables. Stalls on the output hold the
// current result; input is not accepted while a run is in progress or while
// a result is held.
`timescale 1ns / 1ps
`default_nettype none
module deadlock_detection_engine #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire dde_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output dde_pkg::t_out_item      o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [3:0]         i_cfg_data
);
    localparam int NP = MAX_PROCESSES;
    localparam int NR = MAX_RESOURCES;
    localparam int SW = $clog2(NP);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_REPORT = 4'b0100, S_SUM = 4'b1000
    } t_state;

    t_state           r_state;
    logic [3:0]       r_rcount;
    logic [SW-1:0]    r_pos;
    logic [SW:0]      r_idle_cnt;
    logic [NP-1:0]    r_present, r_finished;
    logic             r_found;
    dde_pkg::t_cell_ctl w_ctl;
    logic             w_acc, w_fits, w_slot_ok, w_active, w_out_free;
    logic [NR:0]      w_chain;
    logic [4:0]       w_n;

    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || (o_out_valid && i_out_stall);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_slot_ok  = (int'(i_in_data.process_slot) < NP);
    assign w_n        = (int'(r_rcount) > NR) ? 5'(NR) : {1'b0, r_rcount};
    assign w_active   = r_present[r_pos] && !r_finished[r_pos];
    assign w_chain[0] = 1'b1;
    assign w_fits     = w_chain[NR];

    always_comb begin
        w_ctl = '0;
        w_ctl.load  = w_acc && i_in_data.kind == dde_pkg::K_RUN;
        w_ctl.shift = (r_state == S_SCAN);
        w_ctl.fin   = (r_state == S_SCAN) && w_active && w_fits;
        w_ctl.clear = (r_state == S_SUM) && w_out_free;
    end

    for (genvar g = 0; g < NR; g++) begin : g_cell
        logic w_in_use;
        assign w_in_use = (5'(g) < w_n);
        dde_cell #(.NP(NP)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_set_avail(w_acc && i_in_data.kind == dde_pkg::K_SET_AVAIL
                         && {1'b0, i_in_data.resource_index} == 4'(g)),
            .i_amount   (i_in_data.amount),
            .i_add_held (w_acc && i_in_data.kind == dde_pkg::K_ADD_HELD && w_slot_ok
                         && {1'b0, i_in_data.resource_index} == 4'(g)),
            .i_add_wait (w_acc && i_in_data.kind == dde_pkg::K_ADD_WAIT && w_slot_ok
                         && {1'b0, i_in_data.resource_index} == 4'(g)),
            .i_slot     (SW'(i_in_data.process_slot)),
            .i_active   (w_in_use && w_active),
            .i_fits_in  (w_chain[g]),
            .o_fits     (w_chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rcount    <= 4'd3;
            r_pos       <= '0;
            r_idle_cnt  <= '0;
            r_present   <= '0;
            r_finished  <= '0;
            r_found     <= 1'b0;
            o_out_valid <= 1'b0;
            o_out_data  <= '0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_rcount <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc && i_in_data.kind == dde_pkg::K_ADD_HELD && w_slot_ok) begin
                        r_present[SW'(i_in_data.process_slot)] <= 1'b1;
                    end
                    if (w_ctl.load) begin
                        r_state    <= S_SCAN;
                        r_pos      <= '0;
                        r_idle_cnt <= '0;
                        r_found    <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_pos <= (r_pos == SW'(NP - 1)) ? '0 : r_pos + 1'b1;
                    if (w_ctl.fin) begin
                        r_finished[r_pos] <= 1'b1;
                        r_idle_cnt <= '0;
                    end else if (r_idle_cnt == (SW+1)'(NP - 1)) begin
                        r_state <= S_REPORT;
                        r_pos   <= '0;
                    end else begin
                        r_idle_cnt <= r_idle_cnt + 1'b1;
                    end
                end
                S_REPORT: begin
                    if (!w_active) begin
                        r_pos <= r_pos + 1'b1;
                        if (r_pos == SW'(NP - 1)) begin
                            r_state <= S_SUM;
                        end
                    end else if (w_out_free) begin
                        o_out_valid <= 1'b1;
                        o_out_data  <= '{deadlocked_slot: 4'(r_pos), is_summary: 1'b0,
                                         deadlock_found: 1'b1, last: 1'b0};
                        r_found <= 1'b1;
                        r_finished[r_pos] <= 1'b1;
                        r_pos <= r_pos + 1'b1;
                        if (r_pos == SW'(NP - 1)) begin
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    if (w_out_free) begin
                        o_out_valid <= 1'b1;
                        o_out_data  <= '{deadlocked_slot: 4'd0, is_summary: 1'b1,
                                         deadlock_found: r_found, last: 1'b1};
                        r_present  <= '0;
                        r_finished <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/dde_checker.sv */
// Port-level checker for the deadlock detection engine, bound to the top.
// Depends on dde_pkg and deadlock_detection_engine_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "deadlock_detection_engine_defines.svh"
module dde_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire dde_pkg::t_out_item o_out_data,
    input wire logic              o_cfg_ready
);
    `DDE_ASSERT_IMPL(a_last_is_summary, i_clk, i_rst_n,
        o_out_valid, o_out_data.last == o_out_data.is_summary)
    `DDE_ASSERT_IMPL(a_slot_item_found, i_clk, i_rst_n,
        o_out_valid && !o_out_data.is_summary, o_out_data.deadlock_found)
    `DDE_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n,
        o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `DDE_ASSERT_IMPL(a_cfg_only_idle, i_clk, i_rst_n,
        o_cfg_ready && !(o_out_valid && i_out_stall), !o_in_stall)
endmodule
bind deadlock_detection_engine dde_checker u_dde_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_in_stall(o_in_stall), .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
    .o_out_data(o_out_data), .o_cfg_ready(o_cfg_ready)
);
`default_nettype wire

/* tb/tb_deadlock_detection_engine.sv */
// Self-checking testbench for deadlock_detection_engine: directed, saturation,
// back-pressure and random tests against an in-bench analysis predictor.
// Depends on dde_pkg and the engine RTL.
`timescale 1ns / 1ps
module tb_deadlock_detection_engine;
    localparam int NPROC = 16;
    localparam int NRES = 8;
    localparam int AW = dde_pkg::AVAIL_W;
    localparam int CW = dde_pkg::COUNT_W;
    localparam int RUN_SETTLE = 320;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int HOLD_CYCLES = 700;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    dde_pkg::t_in_item i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    dde_pkg::t_out_item o_out_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [3:0] i_cfg_data;

    deadlock_detection_engine DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [AW-1:0] avail_copy[NRES];
    logic [CW-1:0] held_copy[NPROC][NRES];
    logic [CW-1:0] wait_copy[NPROC][NRES];
    logic [NPROC-1:0] present_copy;
    logic [3:0] res_count_copy;

    dde_pkg::t_out_item verdict_q[$];
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int runs_sent = 0;
    int deadlocks_seen = 0;
    int cfg_writes = 0;
    bit quiet = 0;
    bit hold_req = 0;
    int idle_cycles = 0;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void clear_tables();
        for (int p = 0; p < NPROC; p++)
            for (int r = 0; r < NRES; r++) begin
                held_copy[p][r] = '0;
                wait_copy[p][r] = '0;
            end
        present_copy = '0;
    endfunction

    function automatic void predict_analysis();
        logic [AW-1:0] work[NRES];
        logic [NPROC-1:0] done;
        int n;
        bit progress;
        bit fits;
        bit found;
        int sum;
        dde_pkg::t_out_item res;
        n = (res_count_copy > NRES) ? NRES : res_count_copy;
        done = '0;
        found = 0;
        for (int r = 0; r < NRES; r++) work[r] = avail_copy[r];
        progress = 1;
        while (progress) begin
            progress = 0;
            for (int p = 0; p < NPROC && !progress; p++) begin
                if (present_copy[p] && !done[p]) begin
                    fits = 1;
                    for (int r = 0; r < n; r++)
                        if (work[r] < wait_copy[p][r]) fits = 0;
                    if (fits) begin
                        done[p] = 1;
                        progress = 1;
                        for (int r = 0; r < n; r++) begin
                            sum = work[r] + held_copy[p][r];
                            work[r] = (sum > dde_pkg::AVAIL_MAX) ? dde_pkg::AVAIL_MAX
                                                                 : AW'(sum);
                        end
                    end
                end
            end
        end
        for (int p = 0; p < NPROC; p++)
            if (present_copy[p] && !done[p]) begin
                found = 1;
                res = '{deadlocked_slot: 4'(p), is_summary: 1'b0,
                        deadlock_found: 1'b1, last: 1'b0};
                verdict_q.push_back(res);
            end
        res = '{deadlocked_slot: 4'd0, is_summary: 1'b1, deadlock_found: found, last: 1'b1};
        verdict_q.push_back(res);
        clear_tables();
    endfunction

    function automatic void predict_item(dde_pkg::t_in_item it);
        case (it.kind)
            dde_pkg::K_SET_AVAIL: avail_copy[it.resource_index] = AW'(it.amount);
            dde_pkg::K_ADD_HELD: begin
                if (held_copy[it.process_slot][it.resource_index] != dde_pkg::COUNT_MAX)
                    held_copy[it.process_slot][it.resource_index]++;
                present_copy[it.process_slot] = 1'b1;
            end
            dde_pkg::K_ADD_WAIT: begin
                if (wait_copy[it.process_slot][it.resource_index] != dde_pkg::COUNT_MAX)
                    wait_copy[it.process_slot][it.resource_index]++;
            end
            default: begin
                predict_analysis();
                runs_sent++;
            end
        endcase
    endfunction

    // call at a rising edge; returns at the edge of the transfer, or after a random pause when not quiet
    task automatic send_item(dde_pkg::t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(it);
        items_sent++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic send(logic [1:0] kind, int slot, int res, int amount);
        dde_pkg::t_in_item it;
        it.kind = kind;
        it.process_slot = 4'(slot);
        it.resource_index = 3'(res);
        it.amount = 8'(amount);
        send_item(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (RUN_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_res_count(logic [3:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        res_count_copy = value;
        cfg_writes++;
    endtask

    task automatic test_directed();
        send(dde_pkg::K_RUN, 15, 7, 255);
        send(dde_pkg::K_SET_AVAIL, 0, 0, 255);
        send(dde_pkg::K_SET_AVAIL, 0, 1, 0);
        send(dde_pkg::K_SET_AVAIL, 0, 2, 0);
        send(dde_pkg::K_SET_AVAIL, 0, 7, 255);
        send(dde_pkg::K_ADD_HELD, 0, 0, 0);
        send(dde_pkg::K_ADD_WAIT, 0, 1, 0);
        send(dde_pkg::K_ADD_HELD, 15, 2, 0);
        send(dde_pkg::K_ADD_WAIT, 15, 7, 0);
        send(dde_pkg::K_ADD_HELD, 5, 1, 0);
        send(dde_pkg::K_ADD_WAIT, 5, 0, 0);
        send(dde_pkg::K_ADD_HELD, 7, 1, 0);
        send(dde_pkg::K_ADD_WAIT, 7, 1, 0);
        send(dde_pkg::K_ADD_WAIT, 7, 1, 0);
        send(dde_pkg::K_ADD_WAIT, 9, 0, 0);
        send(dde_pkg::K_RUN, 0, 0, 0);
        send(dde_pkg::K_RUN, 0, 0, 0);
        write_res_count(4'd0);
        send(dde_pkg::K_ADD_HELD, 3, 4, 0);
        send(dde_pkg::K_ADD_WAIT, 3, 4, 0);
        send(dde_pkg::K_RUN, 0, 0, 0);
        write_res_count(4'd15);
        send(dde_pkg::K_SET_AVAIL, 0, 7, 0);
        send(dde_pkg::K_ADD_HELD, 12, 6, 0);
        send(dde_pkg::K_ADD_WAIT, 12, 7, 0);
        send(dde_pkg::K_RUN, 0, 0, 0);
        write_res_count(4'd8);
    endtask

    task automatic test_saturation();
        send(dde_pkg::K_SET_AVAIL, 0, 0, 0);
        for (int i = 0; i < 257; i++) send(dde_pkg::K_ADD_HELD, 2, 0, 0);
        send(dde_pkg::K_ADD_HELD, 10, 1, 0);
        for (int i = 0; i < 2; i++) send(dde_pkg::K_ADD_WAIT, 10, 0, 0);
        send(dde_pkg::K_RUN, 0, 0, 0);
    endtask

    task automatic test_backpressure();
        hold_req = 1;
        send(dde_pkg::K_ADD_HELD, 1, 0, 0);
        send(dde_pkg::K_ADD_WAIT, 1, 1, 0);
        send(dde_pkg::K_ADD_HELD, 4, 1, 0);
        send(dde_pkg::K_ADD_WAIT, 4, 0, 0);
        send(dde_pkg::K_SET_AVAIL, 0, 0, 0);
        send(dde_pkg::K_SET_AVAIL, 0, 1, 0);
        send(dde_pkg::K_RUN, 0, 0, 0);
        send(dde_pkg::K_ADD_HELD, 6, 3, 0);
        send(dde_pkg::K_RUN, 0, 0, 0);
        send(dde_pkg::K_RUN, 0, 0, 0);
        i_in_valid <= 1'b0;
    endtask

    task automatic random_phase(int loads);
        dde_pkg::t_in_item it;
        int slots;
        slots = $urandom_range(1, 16);
        for (int i = 0; i < loads; i++) begin
            it = dde_pkg::t_in_item'($urandom);
            case ($urandom_range(0, 9))
                0, 1: begin
                    it.kind = dde_pkg::K_SET_AVAIL;
                    if ($urandom_range(0, 1)) it.amount = 8'($urandom_range(0, 6));
                end
                2, 3, 4: it.kind = dde_pkg::K_ADD_HELD;
                5, 6, 7: it.kind = dde_pkg::K_ADD_WAIT;
                8: ;
                default: it.kind = dde_pkg::K_ADD_HELD;
            endcase
            if (it.kind != dde_pkg::K_SET_AVAIL && $urandom_range(0, 3) != 0)
                it.process_slot = 4'($urandom_range(0, slots - 1));
            send_item(it);
        end
        it = dde_pkg::t_in_item'($urandom);
        it.kind = dde_pkg::K_RUN;
        send_item(it);
    endtask

    task automatic test_random();
        logic [3:0] counts[5] = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd4};
        int k;
        k = 0;
        while (items_sent < 390) begin
            if ($urandom_range(0, 2) == 0) begin
                write_res_count(($urandom_range(0, 1) != 0) ? counts[k % 5]
                                                            : 4'($urandom));
                k++;
            end
            random_phase($urandom_range(0, 30));
        end
        quiet = 1;
        for (int i = 0; i < 6; i++) random_phase($urandom_range(4, 24));
        drain();
    endtask

    // result side: random stall bursts, a long hold on request, none at the end
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 0;
            end else if (!quiet && i_rst_n && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        dde_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
                $error("unexpected result %p", o_out_data);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                if (o_out_data.is_summary === 1'b0 && want.is_summary === 1'b0)
                    deadlocks_seen++;
                if (o_out_data.deadlocked_slot !== want.deadlocked_slot) begin
                    $error("deadlocked_slot exp %0d got %0d", want.deadlocked_slot,
                           o_out_data.deadlocked_slot);
                    errors++;
                end
                if (o_out_data.is_summary !== want.is_summary) begin
                    $error("is_summary exp %0d got %0d", want.is_summary,
                           o_out_data.is_summary);
                    errors++;
                end
                if (o_out_data.deadlock_found !== want.deadlock_found) begin
                    $error("deadlock_found exp %0d got %0d", want.deadlock_found,
                           o_out_data.deadlock_found);
                    errors++;
                end
                if (o_out_data.last !== want.last) begin
                    $error("last exp %0d got %0d", want.last, o_out_data.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        for (int r = 0; r < NRES; r++) avail_copy[r] = '0;
        clear_tables();
        res_count_copy = 4'd3;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_saturation();
        test_backpressure();
        test_random();
        $display("%0d items, %0d analysis runs, %0d register writes", items_sent,
                 runs_sent, cfg_writes);
        $display("%0d results checked, %0d deadlocked slots reported", results_seen,
                 deadlocks_seen);
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
